@@ rtl/size_class_block_allocator_defines.svh @@
// assertion macros for the size class block allocator
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_DEFINES_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

`define SCBA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scba assertion failed");

`define SCBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scba assertion failed");

`else

`define SCBA_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define SCBA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/scba_pkg.sv @@
`timescale 1ns / 1ps

package scba_pkg;

    localparam int MAX_CLASSES = 4;
    localparam int CLS_W       = 2;
    localparam int SLOT_W      = 6;
    localparam int USED_W      = 7;
    localparam int LEN_W       = 16;
    localparam int STATUS_W    = 3;
    localparam int CFG_IDX_W   = 3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [STATUS_W-1:0] ST_GRANTED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OVERSIZE  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FREED     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd4;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_CLASS0_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLASS1_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLASS2_LENGTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLASS3_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLASS0_BLOCKS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CLASS1_BLOCKS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CLASS2_BLOCKS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CLASS3_BLOCKS = 3'd7;

    localparam logic [LEN_W-1:0]  RST_CLASS0_LENGTH = 16'd32;
    localparam logic [LEN_W-1:0]  RST_CLASS1_LENGTH = 16'd64;
    localparam logic [LEN_W-1:0]  RST_CLASS2_LENGTH = 16'd128;
    localparam logic [LEN_W-1:0]  RST_CLASS3_LENGTH = 16'd256;
    localparam logic [USED_W-1:0] RST_CLASS_BLOCKS  = 7'd16;

    typedef logic [MAX_CLASSES-1:0][LEN_W-1:0]  len_arr_t;
    typedef logic [MAX_CLASSES-1:0][USED_W-1:0] blk_arr_t;

    typedef struct packed {
        logic              action;
        logic [LEN_W-1:0]  request_size;
        logic [CLS_W-1:0]  free_class;
        logic [SLOT_W-1:0] free_slot;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CLS_W-1:0]    granted_class;
        logic [SLOT_W-1:0]   granted_slot;
        logic [USED_W-1:0]   class_used;
    } rsp_t;

    // classified request handed from front to back
    typedef struct packed {
        logic                   is_free;
        logic                   oversize;
        logic [MAX_CLASSES-1:0] fit;
        logic                   cls_bad;
        logic                   slot_bad;
        logic [CLS_W-1:0]       cls;
        logic [SLOT_W-1:0]      slot;
    } cmd_t;

    function automatic logic [USED_W-1:0] capacity(input logic [USED_W-1:0] blocks,
                                                   input logic [USED_W-1:0] limit);
        return (blocks > limit) ? limit : blocks;
    endfunction

endpackage

@@ rtl/scba_fifo.sv @@
`timescale 1ns / 1ps

module scba_fifo
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  scba_pkg::cmd_t push_cmd,
    input  logic          pop,
    output scba_pkg::cmd_t head,
    output logic          full,
    output logic          empty
);

    scba_pkg::cmd_t                  entry_reg [scba_pkg::QUEUE_DEPTH];
    logic [scba_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [scba_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [scba_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [scba_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic [scba_pkg::QCNT_W-1:0]     count_reg;
    logic [scba_pkg::QCNT_W-1:0]     count_next;
    logic                            do_push;
    logic                            do_pop;

    assign full    = (count_reg == scba_pkg::QCNT_W'(scba_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ rtl/scba_front.sv @@
`timescale 1ns / 1ps

module scba_front
#(
    parameter int NUM_CLASSES      = 4,
    parameter int BLOCKS_PER_CLASS = 64
)
(
    input  logic               start,
    input  scba_pkg::req_t     request,
    input  scba_pkg::len_arr_t class_length,
    input  logic               queue_full,
    output logic               busy,
    output logic               push,
    output scba_pkg::cmd_t     cmd
);

    logic [scba_pkg::MAX_CLASSES-1:0] fit;

    always_comb
    begin
        for (int c = 0; c < scba_pkg::MAX_CLASSES; c++)
        begin
            fit[c] = (c < NUM_CLASSES) && (request.request_size <= class_length[c]);
        end
    end

    assign busy = queue_full;
    assign push = start && !queue_full;

    always_comb
    begin
        cmd.is_free  = (request.action == scba_pkg::ACT_FREE);
        cmd.oversize = request.request_size > class_length[NUM_CLASSES-1];
        cmd.fit      = fit;
        cmd.cls_bad  = {1'b0, request.free_class} >=
                       (scba_pkg::CLS_W + 1)'(NUM_CLASSES);
        cmd.slot_bad = {1'b0, request.free_slot} >=
                       (scba_pkg::SLOT_W + 1)'(BLOCKS_PER_CLASS);
        cmd.cls      = request.free_class;
        cmd.slot     = request.free_slot;
    end

endmodule

@@ rtl/scba_back.sv @@
`timescale 1ns / 1ps
`include "size_class_block_allocator_defines.svh"

module scba_back
#(
    parameter int NUM_CLASSES      = 4,
    parameter int BLOCKS_PER_CLASS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  scba_pkg::cmd_t     cmd,
    input  logic               queue_empty,
    output logic               pop,
    input  scba_pkg::blk_arr_t class_blocks,
    output scba_pkg::rsp_t     result,
    output logic               result_valid
);

    localparam int DEPTH = NUM_CLASSES * BLOCKS_PER_CLASS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [scba_pkg::USED_W-1:0] USED_MAX = scba_pkg::USED_W'(BLOCKS_PER_CLASS);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } state_t;

    typedef enum logic [2:0] {
        K_OVER,
        K_EXH,
        K_ALLOC,
        K_FBAD,
        K_FIGN,
        K_FREE
    } kind_t;

    state_t                            state_reg;
    state_t                            state_next;
    kind_t                             kind_reg;
    kind_t                             kind_next;
    logic [scba_pkg::CLS_W-1:0]        cls_reg;
    logic [scba_pkg::CLS_W-1:0]        cls_next;
    logic [scba_pkg::SLOT_W-1:0]       slot_reg;
    logic [scba_pkg::SLOT_W-1:0]       slot_next;
    logic [scba_pkg::SLOT_W-1:0]       pos_reg;
    logic [scba_pkg::SLOT_W-1:0]       pos_next;
    logic [scba_pkg::USED_W-1:0]       used_reg [scba_pkg::MAX_CLASSES];
    logic [scba_pkg::USED_W-1:0]       used_next [scba_pkg::MAX_CLASSES];
    logic [scba_pkg::CLS_W-1:0]        clr_cls_reg;
    logic [scba_pkg::CLS_W-1:0]        clr_cls_next;
    logic [scba_pkg::SLOT_W-1:0]       clr_pos_reg;
    logic [scba_pkg::SLOT_W-1:0]       clr_pos_next;

    logic [scba_pkg::SLOT_W-1:0]       stk_mem [DEPTH];
    logic [scba_pkg::SLOT_W-1:0]       stk_rd_reg;
    logic                              inu_mem [DEPTH];
    logic                              inu_rd_reg;

    logic [AW-1:0]                     stk_raddr;
    logic [AW-1:0]                     inu_raddr;
    logic                              stk_we;
    logic [AW-1:0]                     stk_waddr;
    logic [scba_pkg::SLOT_W-1:0]       stk_wdata;
    logic                              inu_we;
    logic [AW-1:0]                     inu_waddr;
    logic                              inu_wdata;

    logic                              found;
    logic [scba_pkg::CLS_W-1:0]        pick;
    logic [scba_pkg::SLOT_W-1:0]       stack_val;
    logic                              in_use;
    logic [scba_pkg::USED_W-1:0]       cur_used;

    scba_pkg::rsp_t                    result_reg;
    scba_pkg::rsp_t                    result_next;
    logic                              result_valid_reg;
    logic                              result_valid_next;

    logic                              grant_strobe;
    logic                              grant_ok;
    logic                              free_strobe;

    function automatic logic [AW-1:0] addr_of(input logic [scba_pkg::CLS_W-1:0] c,
                                              input logic [scba_pkg::SLOT_W-1:0] p);
        return AW'(int'(c) * BLOCKS_PER_CLASS + int'(p));
    endfunction

    // first class in index order that fits and has a free block
    always_comb
    begin
        found = 1'b0;
        pick  = '0;
        for (int c = scba_pkg::MAX_CLASSES - 1; c >= 0; c--)
        begin
            if (cmd.fit[c] && (used_reg[c] < scba_pkg::capacity(class_blocks[c],
                scba_pkg::USED_W'(BLOCKS_PER_CLASS))))
            begin
                found = 1'b1;
                pick  = scba_pkg::CLS_W'(c);
            end
        end
    end

    assign stk_raddr = addr_of(pick, used_reg[pick][scba_pkg::SLOT_W-1:0]);
    assign inu_raddr = addr_of(cmd.cls, cmd.slot);
    assign stack_val = stk_rd_reg;
    assign in_use    = inu_rd_reg;
    assign cur_used  = used_reg[cls_reg];

    always_comb
    begin
        state_next        = state_reg;
        kind_next         = kind_reg;
        cls_next          = cls_reg;
        slot_next         = slot_reg;
        pos_next          = pos_reg;
        used_next         = used_reg;
        clr_cls_next      = clr_cls_reg;
        clr_pos_next      = clr_pos_reg;
        pop               = 1'b0;
        stk_we            = 1'b0;
        stk_waddr         = addr_of(cls_reg, pos_reg);
        stk_wdata         = slot_reg;
        inu_we            = 1'b0;
        inu_waddr         = addr_of(cls_reg, slot_reg);
        inu_wdata         = 1'b0;
        result_next       = '0;
        result_valid_next = 1'b0;
        case (state_reg)
            // reset contents written one entry a cycle
            S_CLEAR:
            begin
                stk_we    = 1'b1;
                stk_waddr = addr_of(clr_cls_reg, clr_pos_reg);
                stk_wdata = clr_pos_reg;
                inu_we    = 1'b1;
                inu_waddr = addr_of(clr_cls_reg, clr_pos_reg);
                inu_wdata = 1'b0;
                if (clr_pos_reg == scba_pkg::SLOT_W'(BLOCKS_PER_CLASS - 1))
                begin
                    clr_pos_next = '0;
                    if (clr_cls_reg == scba_pkg::CLS_W'(NUM_CLASSES - 1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        clr_cls_next = clr_cls_reg + 1'b1;
                    end
                end
                else
                begin
                    clr_pos_next = clr_pos_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop        = 1'b1;
                    state_next = S_EXEC;
                    cls_next   = cmd.cls;
                    slot_next  = cmd.slot;
                    pos_next   = '0;
                    if (!cmd.is_free)
                    begin
                        cls_next = pick;
                        pos_next = used_reg[pick][scba_pkg::SLOT_W-1:0];
                        if (cmd.oversize)
                        begin
                            kind_next = K_OVER;
                        end
                        else if (found)
                        begin
                            kind_next = K_ALLOC;
                        end
                        else
                        begin
                            kind_next = K_EXH;
                        end
                    end
                    else if (cmd.cls_bad)
                    begin
                        kind_next = K_FBAD;
                    end
                    else if (cmd.slot_bad)
                    begin
                        kind_next = K_FIGN;
                    end
                    else
                    begin
                        kind_next = K_FREE;
                        pos_next  = scba_pkg::SLOT_W'(used_reg[cmd.cls] - 1'b1);
                    end
                end
            end
            S_EXEC:
            begin
                state_next        = S_IDLE;
                result_valid_next = 1'b1;
                case (kind_reg)
                    K_OVER:
                    begin
                        result_next.status = scba_pkg::ST_OVERSIZE;
                    end
                    K_EXH:
                    begin
                        result_next.status = scba_pkg::ST_EXHAUSTED;
                    end
                    K_ALLOC:
                    begin
                        inu_we                    = 1'b1;
                        inu_waddr                 = addr_of(cls_reg, stack_val);
                        inu_wdata                 = 1'b1;
                        used_next[cls_reg]        = cur_used + 1'b1;
                        result_next.status        = scba_pkg::ST_GRANTED;
                        result_next.granted_class = cls_reg;
                        result_next.granted_slot  = stack_val;
                        result_next.class_used    = cur_used + 1'b1;
                    end
                    K_FBAD:
                    begin
                        result_next.status = scba_pkg::ST_IGNORED;
                    end
                    K_FIGN:
                    begin
                        result_next.status     = scba_pkg::ST_IGNORED;
                        result_next.class_used = cur_used;
                    end
                    K_FREE:
                    begin
                        if (!in_use || (cur_used == '0))
                        begin
                            result_next.status     = scba_pkg::ST_IGNORED;
                            result_next.class_used = cur_used;
                        end
                        else
                        begin
                            inu_we                    = 1'b1;
                            stk_we                    = 1'b1;
                            used_next[cls_reg]        = cur_used - 1'b1;
                            result_next.status        = scba_pkg::ST_FREED;
                            result_next.granted_class = cls_reg;
                            result_next.granted_slot  = slot_reg;
                            result_next.class_used    = cur_used - 1'b1;
                        end
                    end
                    default:
                    begin
                        result_next.status = scba_pkg::ST_IGNORED;
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            result_valid_reg <= 1'b0;
            clr_cls_reg      <= '0;
            clr_pos_reg      <= '0;
            for (int c = 0; c < scba_pkg::MAX_CLASSES; c++)
            begin
                used_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            clr_cls_reg      <= clr_cls_next;
            clr_pos_reg      <= clr_pos_next;
            used_reg         <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        cls_reg    <= cls_next;
        slot_reg   <= slot_next;
        pos_reg    <= pos_next;
        result_reg <= result_next;
        if (pop)
        begin
            stk_rd_reg <= stk_mem[stk_raddr];
            inu_rd_reg <= inu_mem[inu_raddr];
        end
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        if (inu_we)
        begin
            inu_mem[inu_waddr] <= inu_wdata;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    assign grant_strobe = result_valid_reg && (result_reg.status == scba_pkg::ST_GRANTED);
    assign grant_ok     = (result_reg.class_used != '0) && (result_reg.class_used <= USED_MAX);
    assign free_strobe  = result_valid_reg && (result_reg.status == scba_pkg::ST_FREED);

    `SCBA_ASSERT_IMP(a_strobe_after_exec, clk, rst_n, result_valid_reg, $past(state_reg == S_EXEC))
    `SCBA_ASSERT_NEXT(a_strobe_single, clk, rst_n, result_valid_reg, !result_valid_reg)
    `SCBA_ASSERT_IMP(a_grant_count, clk, rst_n, grant_strobe, grant_ok)
    `SCBA_ASSERT_IMP(a_free_count, clk, rst_n, free_strobe, result_reg.class_used < USED_MAX)
    `SCBA_ASSERT_IMP(a_no_pop_clear, clk, rst_n, state_reg == S_CLEAR, !pop)

endmodule

@@ rtl/size_class_block_allocator.sv @@
`timescale 1ns / 1ps

// Size class block allocator. A request is taken on any cycle with start high and busy low;
// a two-entry queue sits between the classifier and the executing back end, so busy only
// rises when that queue is full. The back end handles a request by first reading the free
// stack and in-use memories of the chosen class, then updating them and the class's used
// count; it takes no new request from the queue until the current one is done. Each result
// shows up as a one-cycle strobe on result_valid that rises once the request has passed
// through the queue, the read and the update, later still when earlier requests are queued
// or executing. The receiver cannot stall: every strobed result must be captured in that
// cycle. After reset the back end first writes the initial contents of all NUM_CLASSES *
// BLOCKS_PER_CLASS memory entries (256 with the default parameters); requests taken
// meanwhile wait in the queue, and busy rises once it holds two.
// Configuration writes (cfg_ready is always high) must only be made while no request is open.

module size_class_block_allocator
#(
    parameter int NUM_CLASSES      = 4,
    parameter int BLOCKS_PER_CLASS = 64
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  scba_pkg::req_t                    request,
    output scba_pkg::rsp_t                    result,
    output logic                              result_valid,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [scba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [scba_pkg::LEN_W-1:0]        cfg_data
);

    scba_pkg::len_arr_t len_reg;
    scba_pkg::blk_arr_t blk_reg;
    scba_pkg::cmd_t     push_cmd;
    scba_pkg::cmd_t     head_cmd;
    logic               push;
    logic               pop;
    logic               queue_full;
    logic               queue_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg[0] <= scba_pkg::RST_CLASS0_LENGTH;
            len_reg[1] <= scba_pkg::RST_CLASS1_LENGTH;
            len_reg[2] <= scba_pkg::RST_CLASS2_LENGTH;
            len_reg[3] <= scba_pkg::RST_CLASS3_LENGTH;
            for (int c = 0; c < scba_pkg::MAX_CLASSES; c++)
            begin
                blk_reg[c] <= scba_pkg::RST_CLASS_BLOCKS;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                scba_pkg::REG_CLASS0_LENGTH: len_reg[0] <= cfg_data;
                scba_pkg::REG_CLASS1_LENGTH: len_reg[1] <= cfg_data;
                scba_pkg::REG_CLASS2_LENGTH: len_reg[2] <= cfg_data;
                scba_pkg::REG_CLASS3_LENGTH: len_reg[3] <= cfg_data;
                scba_pkg::REG_CLASS0_BLOCKS: blk_reg[0] <= cfg_data[scba_pkg::USED_W-1:0];
                scba_pkg::REG_CLASS1_BLOCKS: blk_reg[1] <= cfg_data[scba_pkg::USED_W-1:0];
                scba_pkg::REG_CLASS2_BLOCKS: blk_reg[2] <= cfg_data[scba_pkg::USED_W-1:0];
                scba_pkg::REG_CLASS3_BLOCKS: blk_reg[3] <= cfg_data[scba_pkg::USED_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    scba_front
    #(
        .NUM_CLASSES      (NUM_CLASSES),
        .BLOCKS_PER_CLASS (BLOCKS_PER_CLASS)
    )
    u_front
    (
        .start        (start),
        .request      (request),
        .class_length (len_reg),
        .queue_full   (queue_full),
        .busy         (busy),
        .push         (push),
        .cmd          (push_cmd)
    );

    scba_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head_cmd),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    scba_back
    #(
        .NUM_CLASSES      (NUM_CLASSES),
        .BLOCKS_PER_CLASS (BLOCKS_PER_CLASS)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (head_cmd),
        .queue_empty  (queue_empty),
        .pop          (pop),
        .class_blocks (blk_reg),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

@@ tb/tb_size_class_block_allocator.sv @@
`timescale 1ns / 1ps

module tb_size_class_block_allocator;
    import scba_pkg::*;

    localparam int NUM_CLASSES      = 4;
    localparam int BLOCKS_PER_CLASS = 64;
    localparam int STALL_LIMIT      = 2000;
    localparam int SETTLE_CYCLES    = 10;
    localparam int RANDOM_PHASES    = 8;
    localparam int ITEMS_PER_PHASE  = 100;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    logic                 busy;
    req_t                 request   = '0;
    rsp_t                 result;
    logic                 result_valid;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [LEN_W-1:0]     cfg_data  = '0;

    class pool_shadow;
        logic [LEN_W-1:0]  lengths [NUM_CLASSES];
        logic [USED_W-1:0] blocks [NUM_CLASSES];
        logic [SLOT_W-1:0] free_slots [NUM_CLASSES][BLOCKS_PER_CLASS];
        logic [USED_W-1:0] used [NUM_CLASSES];
        bit                in_use [NUM_CLASSES][BLOCKS_PER_CLASS];
        rsp_t              predicted_results [$];
        int                mismatches;

        function new();
            mismatches = 0;
            lengths[0] = RST_CLASS0_LENGTH;
            lengths[1] = RST_CLASS1_LENGTH;
            lengths[2] = RST_CLASS2_LENGTH;
            lengths[3] = RST_CLASS3_LENGTH;
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                blocks[c] = RST_CLASS_BLOCKS;
                used[c]   = '0;
                for (int k = 0; k < BLOCKS_PER_CLASS; k++)
                begin
                    free_slots[c][k] = SLOT_W'(k);
                    in_use[c][k]     = 1'b0;
                end
            end
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] index, logic [LEN_W-1:0] data);
            if (index < REG_CLASS0_BLOCKS)
                lengths[index] = data;
            else
                blocks[index - REG_CLASS0_BLOCKS] = data[USED_W-1:0];
        endfunction

        function logic [USED_W-1:0] blocks_offered(int c);
            return (blocks[c] > USED_W'(BLOCKS_PER_CLASS)) ? USED_W'(BLOCKS_PER_CLASS) : blocks[c];
        endfunction

        function void apply_request(req_t r);
            rsp_t              e;
            bit                done;
            logic [USED_W-1:0] n;
            logic [SLOT_W-1:0] s;
            e    = '0;
            done = 1'b0;
            if (r.action == ACT_ALLOC)
            begin
                if (r.request_size > lengths[NUM_CLASSES-1])
                    e.status = ST_OVERSIZE;
                else
                begin
                    e.status = ST_EXHAUSTED;
                    for (int c = 0; c < NUM_CLASSES; c++)
                    begin
                        if (!done && r.request_size <= lengths[c] && used[c] < blocks_offered(c))
                        begin
                            s            = free_slots[c][used[c][SLOT_W-1:0]];
                            in_use[c][s] = 1'b1;
                            used[c]      = used[c] + 1'b1;
                            e.status        = ST_GRANTED;
                            e.granted_class = CLS_W'(c);
                            e.granted_slot  = s;
                            e.class_used    = used[c];
                            done            = 1'b1;
                        end
                    end
                end
            end
            else if (r.free_class >= NUM_CLASSES)
                e.status = ST_IGNORED;
            else if (r.free_slot >= BLOCKS_PER_CLASS || !in_use[r.free_class][r.free_slot]
                     || used[r.free_class] == '0)
            begin
                e.status     = ST_IGNORED;
                e.class_used = used[r.free_class];
            end
            else
            begin
                n = used[r.free_class] - 1'b1;
                in_use[r.free_class][r.free_slot]           = 1'b0;
                used[r.free_class]                          = n;
                free_slots[r.free_class][n[SLOT_W-1:0]]     = r.free_slot;
                e.status        = ST_FREED;
                e.granted_class = r.free_class;
                e.granted_slot  = r.free_slot;
                e.class_used    = n;
            end
            predicted_results.push_back(e);
        endfunction

        function bit pick_in_use(output logic [CLS_W-1:0] cls, output logic [SLOT_W-1:0] slot);
            logic [CLS_W+SLOT_W-1:0] held [$];
            int                      pick;
            for (int c = 0; c < NUM_CLASSES; c++)
                for (int k = 0; k < BLOCKS_PER_CLASS; k++)
                    if (in_use[c][k])
                        held.push_back({CLS_W'(c), SLOT_W'(k)});
            if (held.size() == 0)
                return 1'b0;
            pick = $urandom_range(0, held.size() - 1);
            {cls, slot} = held[pick];
            return 1'b1;
        endfunction

        task report(string msg);
            $display("mismatch at %0t ns: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(rsp_t got);
            rsp_t want;
            if (predicted_results.size() == 0)
            begin
                report($sformatf("result with no request open: %p", got));
                return;
            end
            want = predicted_results.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.granted_class !== want.granted_class)
                report($sformatf("granted_class %0d, want %0d", got.granted_class,
                                 want.granted_class));
            if (got.granted_slot !== want.granted_slot)
                report($sformatf("granted_slot %0d, want %0d", got.granted_slot,
                                 want.granted_slot));
            if (got.class_used !== want.class_used)
                report($sformatf("class_used %0d, want %0d", got.class_used, want.class_used));
        endtask
    endclass

    pool_shadow pool;
    int         idle_run;

    size_class_block_allocator
    #(
        .NUM_CLASSES      (NUM_CLASSES),
        .BLOCKS_PER_CLASS (BLOCKS_PER_CLASS)
    )
    u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result       (result),
        .result_valid (result_valid),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int idle_gap(bit steady);
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic req_t alloc_req(logic [LEN_W-1:0] size);
        req_t r;
        r              = req_t'($bits(req_t)'($urandom));
        r.action       = ACT_ALLOC;
        r.request_size = size;
        return r;
    endfunction

    function automatic req_t free_req(logic [CLS_W-1:0] cls, logic [SLOT_W-1:0] slot);
        req_t r;
        r            = req_t'($bits(req_t)'($urandom));
        r.action     = ACT_FREE;
        r.free_class = cls;
        r.free_slot  = slot;
        return r;
    endfunction

    // start stays high into the next request when there is no gap
    task automatic send_request(req_t r, int gap);
        start   <= 1'b1;
        request <= r;
        do @(posedge clk); while (busy);
        pool.apply_request(r);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pool.predicted_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [LEN_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        pool.set_register(index, data);
    endtask

    task automatic program_classes(len_arr_t lens, len_arr_t counts);
        drain();
        for (int c = 0; c < NUM_CLASSES; c++)
            write_register(REG_CLASS0_LENGTH + CFG_IDX_W'(c), lens[c]);
        for (int c = 0; c < NUM_CLASSES; c++)
            write_register(REG_CLASS0_BLOCKS + CFG_IDX_W'(c), counts[c]);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            pool.check_result(result);
    end

    // stall watchdog: any beat on any channel restarts the count
    initial
    begin
        idle_run = 0;
        while (idle_run < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        len_arr_t          lens;
        len_arr_t          counts;
        req_t              r;
        bit                steady;
        int                span;
        int                acc;
        int                kind;
        int                roll;
        int                target;
        logic [CLS_W-1:0]  hcls;
        logic [SLOT_W-1:0] hslot;

        pool = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset classes: 32/64/128/256 bytes, 16 blocks each
        send_request(alloc_req(16'd0), idle_gap(1'b0));
        send_request(alloc_req(16'd32), idle_gap(1'b0));
        send_request(alloc_req(16'd33), idle_gap(1'b0));
        send_request(alloc_req(16'd256), idle_gap(1'b0));
        send_request(alloc_req(16'd257), idle_gap(1'b0));
        send_request(alloc_req(16'hFFFF), idle_gap(1'b0));
        send_request(free_req(2'd0, 6'd1), idle_gap(1'b0));
        send_request(free_req(2'd0, 6'd1), idle_gap(1'b0));
        send_request(free_req(2'd3, 6'd63), idle_gap(1'b0));
        send_request(alloc_req(16'd1), idle_gap(1'b0));

        // no blocks anywhere, while class zero still holds blocks
        lens   = {16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000};
        counts = {16'h0000, 16'h0000, 16'h0000, 16'h0000};
        program_classes(lens, counts);
        send_request(alloc_req(16'd0), idle_gap(1'b0));
        send_request(alloc_req(16'hFFFF), idle_gap(1'b0));
        send_request(free_req(2'd0, 6'd0), idle_gap(1'b0));
        send_request(free_req(2'd1, 6'd0), idle_gap(1'b0));

        // unordered lengths, count above the slot limit, empty last class
        lens   = {16'd200, 16'hFFFF, 16'd100, 16'd300};
        counts = {16'h0000, 16'hFFFF, 16'h0040, 16'h0001};
        program_classes(lens, counts);
        send_request(alloc_req(16'd100), idle_gap(1'b0));
        send_request(alloc_req(16'd150), idle_gap(1'b0));
        send_request(alloc_req(16'd200), idle_gap(1'b0));
        send_request(alloc_req(16'd201), idle_gap(1'b0));
        send_request(alloc_req(16'd0), idle_gap(1'b0));
        send_request(free_req(2'd0, 6'd1), idle_gap(1'b0));
        send_request(alloc_req(16'd250), idle_gap(1'b0));
        send_request(free_req(2'd2, 6'd0), idle_gap(1'b0));

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            span = $urandom_range(0, 3);
            acc  = 0;
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                case (span)
                    0:
                    begin
                        acc += $urandom_range(0, 128);
                        lens[c] = LEN_W'(acc);
                    end
                    1: lens[c] = LEN_W'($urandom_range(0, 65535));
                    2: lens[c] = ($urandom_range(0, 1) != 0) ? '1 : '0;
                    default:
                    begin
                        acc += $urandom_range(0, 16383);
                        lens[c] = LEN_W'(acc);
                    end
                endcase
                roll = $urandom_range(0, 9);
                if (roll == 0)
                    counts[c] = 16'd0;
                else if (roll == 1)
                    counts[c] = LEN_W'(BLOCKS_PER_CLASS);
                else if (roll == 2)
                    counts[c] = LEN_W'($urandom_range(BLOCKS_PER_CLASS + 1, 127));
                else if (roll == 3)
                    counts[c] = 16'd1;
                else
                    counts[c] = LEN_W'($urandom_range(2, 24));
                // upper data bits are don't-care for count registers
                counts[c][LEN_W-1:USED_W] = (LEN_W - USED_W)'($urandom);
            end
            program_classes(lens, counts);
            steady = ($urandom_range(0, 3) == 0);

            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 50)
                begin
                    roll = $urandom_range(0, 9);
                    if (roll < 6)
                    begin
                        target = int'(pool.lengths[$urandom_range(0, NUM_CLASSES - 1)]);
                        target += int'($urandom_range(0, 2)) - 1;
                        if (target < 0)
                            target = 0;
                        if (target > 65535)
                            target = 65535;
                    end
                    else if (roll < 8)
                        target = $urandom_range(0, int'(pool.lengths[NUM_CLASSES-1]));
                    else if (roll == 8)
                        target = 0;
                    else
                        target = $urandom_range(0, 65535);
                    r = alloc_req(LEN_W'(target));
                end
                else if (kind < 88 && pool.pick_in_use(hcls, hslot))
                    r = free_req(hcls, hslot);
                else if (kind < 88)
                    r = alloc_req(LEN_W'($urandom));
                else
                    r = free_req(CLS_W'($urandom), SLOT_W'($urandom));
                send_request(r, idle_gap(steady));
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pool.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/scba_pkg.sv
rtl/scba_fifo.sv
rtl/scba_front.sv
rtl/scba_back.sv
rtl/size_class_block_allocator.sv
tb/tb_size_class_block_allocator.sv
